// ===== design/rgb_sharpen_3x3_clamp_top_assert.svh =====
// rgb_sharpen_3x3_clamp_top_assert.svh: assertion macros for the sharpen filter checker.
// No dependencies; included by rsc_checker.sv.
`ifndef RGB_SHARPEN_3X3_CLAMP_TOP_ASSERT_SVH
`define RGB_SHARPEN_3X3_CLAMP_TOP_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define RSC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define RSC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/rsc_pkg.sv =====
// rsc_pkg: shared types, register codes and constants of the RGB 3x3 sharpen filter.
// No dependencies; imported by every RTL module of the block.
`timescale 1ns / 1ps

package rsc_pkg;

	localparam int MAX_WIDTH_DEF = 1024;

	localparam int CHAN_W   = 8;
	localparam int NUM_CHAN = 3;
	localparam int PIX_W    = CHAN_W * NUM_CHAN;

	// configuration register widths
	localparam int FW_W       = 11;
	localparam int FH_W       = 12;
	localparam int SPLIT_W    = 11;
	localparam int GAIN_W     = 4;
	localparam int BIAS_W     = 9;
	localparam int CFG_DATA_W = 12;
	localparam int CFG_IDX_W  = 3;

	localparam logic [FW_W-1:0]           FW_RST    = 11'd640;
	localparam logic [FH_W-1:0]           FH_RST    = 12'd480;
	localparam logic [SPLIT_W-1:0]        SPLIT_RST = 11'd320;
	localparam logic [GAIN_W-1:0]         GAIN_RST  = 4'd3;
	localparam logic signed [BIAS_W-1:0]  BIAS_RST  = 9'sd1;

	// kernel: 9*centre minus the eight neighbours, result clamped to video range
	localparam int CTR_WEIGHT = 9;
	localparam int CLAMP_LO   = 16;
	localparam int CLAMP_HI   = 240;

	localparam int WIN_COLS = 6;
	localparam int NB_TAPS  = 9;
	localparam int NB_CTR   = 4;

	// channel 2 is red, 1 is green, 0 is blue
	typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] pixel_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAME_WIDTH  = 3'd0,
		CFG_FRAME_HEIGHT = 3'd1,
		CFG_SPLIT_COLUMN = 3'd2,
		CFG_GAIN         = 3'd3,
		CFG_BIAS         = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic                     inner;
		logic [GAIN_W-1:0]        gain;
		logic signed [BIAS_W-1:0] bias;
	} kern_ctl_t;

endpackage

// ===== design/rsc_ram.sv =====
// rsc_ram: generic single-write, single-read RAM with registered read data.
// Depends on rsc_pkg for default sizes.
`timescale 1ns / 1ps

module rsc_ram import rsc_pkg::*; #(
	parameter int WIDTH = PIX_W,
	parameter int DEPTH = MAX_WIDTH_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// read returns the old contents on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/rsc_kernel.sv =====
// rsc_kernel: per-channel 3x3 sharpen, gain, bias and clamp, or centre pass-through.
// Depends on rsc_pkg (pixel_t, kern_ctl_t, kernel constants).
`timescale 1ns / 1ps

module rsc_kernel import rsc_pkg::*; (
	input  pixel_t    nb [NB_TAPS],
	input  kern_ctl_t ctl,
	output pixel_t    res
);

	localparam int SUM_W = CHAN_W + 3;
	localparam int K_W   = CHAN_W + 5;
	localparam int V_W   = K_W + GAIN_W + 2;

	logic [SUM_W-1:0]        nsum   [NUM_CHAN];
	logic [K_W-1:0]          ctr9   [NUM_CHAN];
	logic signed [K_W-1:0]   kern   [NUM_CHAN];
	logic signed [V_W-1:0]   scaled [NUM_CHAN];
	logic signed [V_W-1:0]   biased [NUM_CHAN];
	logic [CHAN_W-1:0]       clip   [NUM_CHAN];

	always_comb begin
		for (int c = 0; c < NUM_CHAN; c++) begin
			nsum[c] = '0;
			for (int t = 0; t < NB_TAPS; t++) begin
				if (t != NB_CTR) begin
					nsum[c] = nsum[c] + SUM_W'(nb[t][c]);
				end
			end
			ctr9[c]   = K_W'(nb[NB_CTR][c]) * K_W'(CTR_WEIGHT);
			kern[c]   = $signed(ctr9[c]) - $signed(K_W'(nsum[c]));
			scaled[c] = V_W'(kern[c]) * $signed(V_W'(ctl.gain));
			biased[c] = scaled[c] + V_W'($signed(ctl.bias));
			if (biased[c] < V_W'(CLAMP_LO)) begin
				clip[c] = CHAN_W'(CLAMP_LO);
			end else if (biased[c] > V_W'(CLAMP_HI)) begin
				clip[c] = CHAN_W'(CLAMP_HI);
			end else begin
				clip[c] = biased[c][CHAN_W-1:0];
			end
			res[c] = ctl.inner ? clip[c] : nb[NB_CTR][c];
		end
	end

endmodule

// ===== design/rgb_sharpen_3x3_clamp_top.sv =====
// rgb_sharpen_3x3_clamp_top: streaming 3x3 sharpen of RGB raster pixels; uses rsc_pkg,
// rsc_ram (two line stores) and rsc_kernel (per-channel sharpen and clamp).
// Throughput: one pixel word in and one result word out per cycle, set by the single-pass
// window datapath; the input stalls only while a finished result word is held back.
// Release: a pixel leaves the width in use + 1 words after it entered; the word that
// releases it goes through s1 and then s2 before the result shows. Reset: control, positions
// and window clear, the registers load their defaults; line stores are not cleared and need no sweep.
`timescale 1ns / 1ps

module rgb_sharpen_3x3_clamp_top import rsc_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// pixel input channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [CHAN_W-1:0]     red_in,
	input  logic [CHAN_W-1:0]     green_in,
	input  logic [CHAN_W-1:0]     blue_in,
	input  logic                  drain,
	// result channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [CHAN_W-1:0]     red_out,
	output logic [CHAN_W-1:0]     green_out,
	output logic [CHAN_W-1:0]     blue_out,
	output logic                  frame_last,
	// register write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// column index, width value, compare width, row width, lag arithmetic width
	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int XW = (WW > FW_W) ? WW : FW_W;
	localparam int RW = FH_W;
	localparam int PW = RW + WW + 4;

	// ---------------------------------------------------------------------------------
	// Configuration registers. Writes are always taken.
	// ---------------------------------------------------------------------------------
	logic [FW_W-1:0]          frame_width_q;
	logic [FH_W-1:0]          frame_height_q;
	logic [SPLIT_W-1:0]       split_column_q;
	logic [GAIN_W-1:0]        gain_q;
	logic signed [BIAS_W-1:0] bias_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FW_RST;
			frame_height_q <= FH_RST;
			split_column_q <= SPLIT_RST;
			gain_q         <= GAIN_RST;
			bias_q         <= BIAS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data[FW_W-1:0];
				CFG_FRAME_HEIGHT: frame_height_q <= cfg_data[FH_W-1:0];
				CFG_SPLIT_COLUMN: split_column_q <= cfg_data[SPLIT_W-1:0];
				CFG_GAIN:         gain_q         <= cfg_data[GAIN_W-1:0];
				CFG_BIAS:         bias_q         <= $signed(cfg_data[BIAS_W-1:0]);
				default: ;
			endcase
		end
	end

	// Width in use is frame_width limited to 1..MAX_WIDTH; a zero height counts as one row.
	logic [XW-1:0] fw_x;
	logic [XW-1:0] w_x;
	logic [WW-1:0] used_w;
	logic [RW-1:0] used_h;

	assign fw_x = XW'(frame_width_q);

	always_comb begin
		if (fw_x == '0) begin
			w_x = XW'(1);
		end else if (fw_x > XW'(MAX_WIDTH)) begin
			w_x = XW'(MAX_WIDTH);
		end else begin
			w_x = fw_x;
		end
	end

	assign used_w = WW'(w_x);
	assign used_h = (frame_height_q == '0) ? RW'(1) : frame_height_q;

	// ---------------------------------------------------------------------------------
	// Handshake. s1 holds the word whose line-store data is being read, s2 the result.
	// s1 moves on unless it carries a result and s2 is blocked.
	// ---------------------------------------------------------------------------------
	logic valid_s1, emit_s1, inner_s1, last_s1, fwd_s1;
	logic valid_s2;
	logic s2_free, s1_go, in_acc, load_s1;

	assign s2_free  = !valid_s2 || !out_stall;
	assign s1_go    = valid_s1 && (!emit_s1 || s2_free);
	assign in_stall = valid_s1 && !s1_go;
	assign in_acc   = in_valid && !in_stall;

	// ---------------------------------------------------------------------------------
	// Raster positions, evaluated for the word at the input.
	// ---------------------------------------------------------------------------------
	logic [RW-1:0] in_row_q, out_row_q;
	logic [CW-1:0] in_col_q, out_col_q;

	logic          in_wrap0, out_wrap0, in_wrap1, out_wrap1;
	logic [CW-1:0] ic0, ic2, oc0, oc2;
	logic [WW-1:0] ic1, oc1;
	logic [RW-1:0] ir0, ir2;
	logic [RW:0]   or0, or2;
	logic          done, active, emit, inner, last;

	logic signed [PW-1:0] row_gap, col_gap, lag;

	always_comb begin
		// a column left past a shrunk width wraps to the next row
		in_wrap0  = WW'(in_col_q) >= used_w;
		ic0       = in_wrap0 ? '0 : in_col_q;
		ir0       = (in_wrap0 && (in_row_q < used_h)) ? in_row_q + RW'(1) : in_row_q;
		out_wrap0 = WW'(out_col_q) >= used_w;
		oc0       = out_wrap0 ? '0 : out_col_q;
		or0       = {1'b0, out_row_q} + (RW+1)'(out_wrap0);

		// all rows in: further words only clock out the tail
		done   = ir0 >= used_h;
		active = done || !drain;

		// advance the input position
		ic1      = WW'(ic0) + WW'(1);
		in_wrap1 = ic1 >= used_w;
		ic2      = in_wrap1 ? '0 : ic1[CW-1:0];
		ir2      = (in_wrap1 && !done) ? ir0 + RW'(1) : ir0;

		// release the output pixel once the input is a line plus two pixels ahead
		row_gap = PW'(ir2) - PW'(or0);
		col_gap = PW'(ic2) - PW'(oc0);
		lag     = row_gap * PW'(used_w) + col_gap;
		emit    = done || (lag >= $signed(PW'(used_w) + PW'(2)));

		// interior: not first or last row, right of the split, not the last column
		inner = (or0 >= (RW+1)'(1)) &&
			((or0 + (RW+1)'(1)) < (RW+1)'(used_h)) &&
			(XW'(oc0) > XW'(split_column_q)) &&
			((WW'(oc0) + WW'(1)) < used_w);

		// advance the output position
		oc1       = WW'(oc0) + WW'(1);
		out_wrap1 = oc1 >= used_w;
		oc2       = out_wrap1 ? '0 : oc1[CW-1:0];
		or2       = or0 + (RW+1)'(out_wrap1);
		last      = or2 >= (RW+1)'(used_h);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q  <= '0;
			in_col_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
		end else if (in_acc) begin
			if (!active) begin
				// early drain: keep only the wrap of the positions
				in_row_q  <= ir0;
				in_col_q  <= ic0;
				out_row_q <= or0[RW-1:0];
				out_col_q <= oc0;
			end else if (emit && last) begin
				// frame complete: start over
				in_row_q  <= '0;
				in_col_q  <= '0;
				out_row_q <= '0;
				out_col_q <= '0;
			end else begin
				in_row_q <= ir2;
				in_col_q <= ic2;
				if (emit) begin
					out_row_q <= or2[RW-1:0];
					out_col_q <= oc2;
				end else begin
					out_row_q <= or0[RW-1:0];
					out_col_q <= oc0;
				end
			end
		end
	end

	// ---------------------------------------------------------------------------------
	// Stage 1: line-store read in flight, pixel and decisions held.
	// ---------------------------------------------------------------------------------
	assign load_s1 = in_acc && active;

	logic [CW-1:0] addr_s1;
	pixel_t        pix_s1, fwd_top_s1, fwd_mid_s1;
	pixel_t        upper_rd, middle_rd;
	pixel_t        top_eff, mid_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			emit_s1  <= 1'b0;
			inner_s1 <= 1'b0;
			last_s1  <= 1'b0;
			fwd_s1   <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
			emit_s1  <= emit;
			inner_s1 <= inner;
			last_s1  <= emit && last;
			// the store write of the leaving word lands on the same edge as this read
			fwd_s1   <= s1_go && (addr_s1 == ic0);
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			addr_s1    <= ic0;
			pix_s1     <= done ? '0 : {red_in, green_in, blue_in};
			fwd_top_s1 <= mid_eff;
			fwd_mid_s1 <= pix_s1;
		end
	end

	// bypass the store when the previous word wrote this address on the read edge
	assign top_eff = fwd_s1 ? fwd_top_s1 : upper_rd;
	assign mid_eff = fwd_s1 ? fwd_mid_s1 : middle_rd;

	// upper line takes the old middle entry, middle line takes the new pixel
	rsc_ram #(
		.WIDTH (PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_upper_line (
		.clk   (clk),
		.we    (s1_go),
		.waddr (addr_s1),
		.wdata (mid_eff),
		.re    (load_s1),
		.raddr (ic0),
		.rdata (upper_rd)
	);

	rsc_ram #(
		.WIDTH (PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_middle_line (
		.clk   (clk),
		.we    (s1_go),
		.waddr (addr_s1),
		.wdata (pix_s1),
		.re    (load_s1),
		.raddr (ic0),
		.rdata (middle_rd)
	);

	// ---------------------------------------------------------------------------------
	// 3x3 window: two older columns in registers, the newest column from the stores and s1.
	// ---------------------------------------------------------------------------------
	pixel_t    win_q [WIN_COLS];
	pixel_t    nb [NB_TAPS];
	pixel_t    res_s1;
	kern_ctl_t kctl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WIN_COLS; i++) begin
				win_q[i] <= '0;
			end
		end else if (s1_go) begin
			// shift one column left
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top_eff;
			win_q[4] <= mid_eff;
			win_q[5] <= pix_s1;
		end
	end

	always_comb begin
		nb[0] = win_q[0];
		nb[1] = win_q[3];
		nb[2] = top_eff;
		nb[3] = win_q[1];
		nb[4] = win_q[4];
		nb[5] = mid_eff;
		nb[6] = win_q[2];
		nb[7] = win_q[5];
		nb[8] = pix_s1;
	end

	assign kctl = '{inner: inner_s1, gain: gain_q, bias: bias_q};

	rsc_kernel u_kernel (
		.nb  (nb),
		.ctl (kctl),
		.res (res_s1)
	);

	// ---------------------------------------------------------------------------------
	// Stage 2: result register. Hold while stalled.
	// ---------------------------------------------------------------------------------
	pixel_t pix_s2;
	logic   last_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_go && emit_s1) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && emit_s1) begin
			pix_s2  <= res_s1;
			last_s2 <= last_s1;
		end
	end

	assign out_valid  = valid_s2;
	assign red_out    = pix_s2[2];
	assign green_out  = pix_s2[1];
	assign blue_out   = pix_s2[0];
	assign frame_last = last_s2;

endmodule

// ===== design/rsc_checker.sv =====
// rsc_checker: port-level assertions on the sharpen filter top level, bound to it below.
// Depends on rsc_pkg and the macros in rgb_sharpen_3x3_clamp_top_assert.svh.
`timescale 1ns / 1ps
`include "rgb_sharpen_3x3_clamp_top_assert.svh"

module rsc_checker import rsc_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic [CHAN_W-1:0] red_out,
	input logic [CHAN_W-1:0] green_out,
	input logic [CHAN_W-1:0] blue_out,
	input logic              frame_last
);

	// input backs up only behind a result word that is itself held
	`RSC_ASSERT_IMP(a_stall_cause, clk, arst_n, in_stall, out_valid && out_stall, "input stalled without a blocked result word")

	// a fresh result word traces back to an earlier accepted input word
	`RSC_ASSERT_IMP(a_result_source, clk, arst_n, $rose(out_valid), $past(in_valid && !in_stall, 2), "result word without an accepted input word")

	// a held result word keeps its value
	`RSC_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(red_out) && $stable(green_out) && $stable(blue_out) && $stable(frame_last), "stalled result word changed")

	// a result word goes away only once taken
	`RSC_ASSERT_IMP(a_out_taken, clk, arst_n, $fell(out_valid), $past(!out_stall), "result word dropped while stalled")

endmodule

bind rgb_sharpen_3x3_clamp_top rsc_checker u_rsc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.red_out    (red_out),
	.green_out  (green_out),
	.blue_out   (blue_out),
	.frame_last (frame_last)
);

// ===== tb/sv/tb_rgb_sharpen_3x3_clamp_top.sv =====
// tb_rgb_sharpen_3x3_clamp_top: self-checking bench for the RGB 3x3 sharpen filter.
// Needs rsc_pkg and the rgb_sharpen_3x3_clamp_top RTL; a scoreboard class predicts
// every result word from the accepted pixel words and checks the output stream.
`timescale 1ns / 1ps

module tb_rgb_sharpen_3x3_clamp_top;
	import rsc_pkg::*;

	localparam int RANDOM_ITEMS  = 1550;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_LIMIT   = 5000;
	localparam int TIMEOUT_NS    = 1000000;
	localparam int REPORT_MAX    = 10;
	// directed frame, row-major bit per pixel: rows 0011 / 0101 / 0011
	localparam logic [11:0] EDGE_MASK = 12'b1100_1010_1100;

	typedef enum int {PIX_UNIFORM, PIX_SMOOTH, PIX_EXTREME} pix_style_t;

	typedef struct packed {
		pixel_t px;
		logic   last;
	} pixel_result_t;

	// Scoreboard: holds its own copy of the line stores, window, positions and
	// registers; take_pixel() predicts, match_pixel() checks in order.
	class pixel_scoreboard;
		pixel_t          above_row [MAX_WIDTH_DEF];
		pixel_t          centre_row[MAX_WIDTH_DEF];
		pixel_t          win       [WIN_COLS];
		int unsigned     wr_row, wr_col, rd_row, rd_col;
		logic [FW_W-1:0]          width_reg;
		logic [FH_W-1:0]          height_reg;
		logic [SPLIT_W-1:0]       split_reg;
		logic [GAIN_W-1:0]        gain_reg;
		logic signed [BIAS_W-1:0] bias_reg;
		pixel_result_t   pending_pixels[$];
		int unsigned     mismatches, checked, frames_done, consumed;
		int unsigned     sharpened, clamped_lo, clamped_hi, ignored_drains;

		function new();
			foreach (above_row[i]) begin
				above_row[i]  = '0;
				centre_row[i] = '0;
			end
			foreach (win[i]) win[i] = '0;
			wr_row = 0;
			wr_col = 0;
			rd_row = 0;
			rd_col = 0;
			width_reg  = FW_RST;
			height_reg = FH_RST;
			split_reg  = SPLIT_RST;
			gain_reg   = GAIN_RST;
			bias_reg   = BIAS_RST;
		endfunction

		function int unsigned row_width();
			int unsigned w;
			w = width_reg;
			if (w < 1) w = 1;
			if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
			return w;
		endfunction

		function int unsigned frame_rows();
			return (height_reg == 0) ? 1 : height_reg;
		endfunction

		function int pending();
			return pending_pixels.size();
		endfunction

		// All pixels of the frame are in: further words only flush the tail.
		function bit in_tail();
			int unsigned row;
			row = wr_row;
			if (wr_col >= row_width() && row < frame_rows()) row++;
			return row >= frame_rows();
		endfunction

		function void note_config(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_FRAME_WIDTH:  width_reg  = data[FW_W-1:0];
				CFG_FRAME_HEIGHT: height_reg = data[FH_W-1:0];
				CFG_SPLIT_COLUMN: split_reg  = data[SPLIT_W-1:0];
				CFG_GAIN:         gain_reg   = data[GAIN_W-1:0];
				CFG_BIAS:         bias_reg   = data[BIAS_W-1:0];
				default: ;
			endcase
		endfunction

		// 9*centre minus the eight neighbours, times gain, plus bias, clamped.
		function logic [CHAN_W-1:0] kernel_clamp(input pixel_t taps [NB_TAPS], int ch);
			int total, centre, gain_i, bias_i, v;
			total  = 0;
			centre = taps[NB_CTR][ch];
			gain_i = gain_reg;
			bias_i = bias_reg;
			for (int i = 0; i < NB_TAPS; i++) total += int'(taps[i][ch]);
			v = gain_i * (CTR_WEIGHT * centre - (total - centre)) + bias_i;
			if (v < CLAMP_LO) begin
				v = CLAMP_LO;
				clamped_lo++;
			end else if (v > CLAMP_HI) begin
				v = CLAMP_HI;
				clamped_hi++;
			end
			return v[CHAN_W-1:0];
		endfunction

		function void take_pixel(pixel_t px, logic drain_bit);
			int unsigned       w, h, idx;
			longint unsigned   cnt, oid;
			bit                done, emit, inner;
			pixel_t            pix, top, mid, res;
			pixel_t            taps[NB_TAPS];
			pixel_result_t     word;
			w = row_width();
			h = frame_rows();
			if (wr_col >= w) begin
				wr_col = 0;
				if (wr_row < h) wr_row++;
			end
			if (rd_col >= w) begin
				rd_col = 0;
				rd_row++;
			end
			done = wr_row >= h;
			// drop a drain word that arrives while pixels are still due
			if (!done && drain_bit) begin
				ignored_drains++;
				return;
			end
			consumed++;
			pix = done ? '0 : px;
			idx = (wr_col < MAX_WIDTH_DEF) ? wr_col : MAX_WIDTH_DEF - 1;
			top = above_row[idx];
			mid = centre_row[idx];
			above_row[idx]  = mid;
			centre_row[idx] = pix;
			taps[0] = win[0]; taps[1] = win[3]; taps[2] = top;
			taps[3] = win[1]; taps[4] = win[4]; taps[5] = mid;
			taps[6] = win[2]; taps[7] = win[5]; taps[8] = pix;
			win[0] = win[3];
			win[1] = win[4];
			win[2] = win[5];
			win[3] = top;
			win[4] = mid;
			win[5] = pix;
			wr_col++;
			if (wr_col >= w) begin
				wr_col = 0;
				if (!done) wr_row++;
			end
			emit = done;
			if (!done) begin
				cnt  = wr_row;
				cnt  = cnt * w + wr_col;
				oid  = rd_row;
				oid  = oid * w + rd_col;
				emit = cnt >= oid + w + 2;
			end
			if (!emit) return;
			inner = rd_row >= 1 && rd_row + 1 < h && rd_col > split_reg && rd_col + 1 < w;
			if (inner) begin
				for (int ch = 0; ch < NUM_CHAN; ch++) res[ch] = kernel_clamp(taps, ch);
				sharpened++;
			end else begin
				res = taps[NB_CTR];
			end
			word.px   = res;
			word.last = 1'b0;
			rd_col++;
			if (rd_col >= w) begin
				rd_col = 0;
				rd_row++;
			end
			if (rd_row >= h) begin
				word.last = 1'b1;
				wr_row = 0;
				wr_col = 0;
				rd_row = 0;
				rd_col = 0;
				frames_done++;
			end
			pending_pixels.push_back(word);
		endfunction

		function void match_pixel(pixel_t px, logic last);
			pixel_result_t want;
			if (pending_pixels.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected result word: r=%0d g=%0d b=%0d last=%0b",
						px[2], px[1], px[0], last);
				return;
			end
			want = pending_pixels.pop_front();
			checked++;
			if (px[2] !== want.px[2] || px[1] !== want.px[1] || px[0] !== want.px[0] ||
					last !== want.last) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("result word %0d: expected r=%0d g=%0d b=%0d last=%0b, got r=%0d g=%0d b=%0d last=%0b",
						checked, want.px[2], want.px[1], want.px[0], want.last,
						px[2], px[1], px[0], last);
			end
		endfunction
	endclass

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_stall;
	logic [CHAN_W-1:0]     red_in    = '0;
	logic [CHAN_W-1:0]     green_in  = '0;
	logic [CHAN_W-1:0]     blue_in   = '0;
	logic                  drain     = 1'b0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [CHAN_W-1:0]     red_out;
	logic [CHAN_W-1:0]     green_out;
	logic [CHAN_W-1:0]     blue_out;
	logic                  frame_last;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	cfg_idx_t              cfg_index = CFG_FRAME_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	pixel_scoreboard sb;
	int gap_pct   = 0;
	int stall_pct = 0;

	rgb_sharpen_3x3_clamp_top i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.red_in     (red_in),
		.green_in   (green_in),
		.blue_in    (blue_in),
		.drain      (drain),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.red_out    (red_out),
		.green_out  (green_out),
		.blue_out   (blue_out),
		.frame_last (frame_last),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Result side: check the word taken at this edge, then pick next cycle's stall.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.match_pixel({red_out, green_out, blue_out}, frame_last);
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Hard stop in case the handshake hangs.
	initial begin
		#(TIMEOUT_NS);
		$display("tb_rgb_sharpen_3x3_clamp_top NOT OK");
		$finish;
	end

	// Idle the sender at random, then offer one word and hold it until taken.
	// valid stays high across back-to-back words, so it never toggles in one step.
	task automatic send_word(pixel_t px, logic drain_bit);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		red_in   <= px[2];
		green_in <= px[1];
		blue_in  <= px[0];
		drain    <= drain_bit;
		do @(posedge clk); while (!(in_valid && !in_stall));
		sb.take_pixel(px, drain_bit);
	endtask

	// Drop valid, wait for every predicted word to come out, then let the
	// pipeline run dry: a word that releases no result may still be in flight.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Leaves cfg_valid high so that writes can follow back to back.
	task automatic write_reg(cfg_idx_t idx, int value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_W'(value);
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		sb.note_config(idx, CFG_DATA_W'(value));
	endtask

	task automatic apply_setup(int w, int h, int split, int gain_v, int bias_v);
		settle();
		write_reg(CFG_FRAME_WIDTH, w);
		write_reg(CFG_FRAME_HEIGHT, h);
		write_reg(CFG_SPLIT_COLUMN, split);
		write_reg(CFG_GAIN, gain_v);
		write_reg(CFG_BIAS, bias_v);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_idling(int mode);
		case (mode)
			0: begin gap_pct = 0;  stall_pct <= 0;  end
			1: begin gap_pct = 46; stall_pct <= 0;  end
			2: begin gap_pct = 0;  stall_pct <= 46; end
			default: begin gap_pct = 31; stall_pct <= 31; end
		endcase
	endtask

	function automatic pixel_t make_pixel(pix_style_t style, pixel_t base);
		pixel_t p;
		int     v;
		p = pixel_t'($urandom);
		for (int ch = 0; ch < NUM_CHAN; ch++) begin
			case (style)
				PIX_SMOOTH: begin
					// small ripple around a base keeps neighbouring pixels close in value
					v = int'(base[ch]) + int'($urandom_range(0, 12)) - 6;
					if (v < 0) v = 0;
					if (v > 255) v = 255;
					p[ch] = v[CHAN_W-1:0];
				end
				PIX_EXTREME: p[ch] = p[ch][0] ? 8'hFF : 8'h00;
				default: ;
			endcase
		end
		return p;
	endfunction

	// Feed one frame until its last word is predicted. Sprinkle early drains
	// (ignored) among the pixels; mix drain and pixel words in the tail.
	// A nonzero cut_at cuts the height short after that many pixels.
	task automatic run_frame(pix_style_t style, int cut_at);
		int unsigned start_count;
		int          fed;
		pixel_t      base;
		start_count = sb.frames_done;
		fed  = 0;
		base = pixel_t'($urandom);
		while (sb.frames_done == start_count) begin
			if (!sb.in_tail()) begin
				if ($urandom_range(99) < 6) begin
					send_word(make_pixel(style, base), 1'b1);
				end else begin
					send_word(make_pixel(style, base), 1'b0);
					fed++;
					if (fed == cut_at) begin
						// shrink the height to at most the rows already in: ends the frame
						settle();
						write_reg(CFG_FRAME_HEIGHT, $urandom_range(0, sb.wr_row));
						write_reg(CFG_GAIN, $urandom_range(0, 15));
						cfg_valid <= 1'b0;
					end
				end
			end else if ($urandom_range(99) < 30) begin
				send_word(make_pixel(PIX_UNIFORM, base), 1'b0);
			end else begin
				send_word(pixel_t'($urandom), 1'b1);
			end
		end
	endtask

	initial begin
		int unsigned start_items;
		int          phase, w, h, split, gain_v, bias_v, r;
		int unsigned leftover;
		bit          on;

		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: a 4x3 edge pattern at the top gain and bias. Red and green each hit
		// both clamps, flat blue the upper one.
		apply_setup(4, 3, 0, 15, 255);
		for (int i = 0; i < 12; i++) begin
			on = EDGE_MASK[i];
			send_word({on ? 8'hFF : 8'h00, on ? 8'h00 : 8'hFF, 8'd128}, 1'b0);
			if (i == 5) send_word(pixel_t'($urandom), 1'b1);
		end
		run_frame(PIX_UNIFORM, 0);

		// Width and height of zero: a single pixel frame, passed through.
		apply_setup(0, 0, 2047, 0, -256);
		send_word({8'hFF, 8'h00, 8'hAA}, 1'b0);
		run_frame(PIX_UNIFORM, 0);

		// Tallest height register, cut short in the middle of the frame.
		set_idling(3);
		apply_setup(5, 4095, 0, 2, 20);
		run_frame(PIX_SMOOTH, 22);

		// Widest width register (clamped to the line store size), one row.
		set_idling(1);
		apply_setup(2047, 1, 3, 9, -40);
		run_frame(PIX_UNIFORM, 0);

		// Random setups and frames, mostly small, idling pattern per phase.
		start_items = sb.consumed;
		phase = 0;
		while (sb.consumed - start_items < RANDOM_ITEMS) begin
			set_idling(phase % 4);
			r = $urandom_range(99);
			if (r < 8) w = $urandom_range(0, 2);
			else if (r < 13) w = $urandom_range(13, 40);
			else w = $urandom_range(3, 12);
			r = $urandom_range(99);
			h = (r < 10) ? $urandom_range(0, 2) : $urandom_range(3, 7);
			r = $urandom_range(99);
			if (r < 25) split = 0;
			else if (r < 35) split = $urandom_range(1024, 2047);
			else split = $urandom_range(0, w);
			r = $urandom_range(99);
			if (r < 15) gain_v = $urandom_range(0, 1) ? 15 : 0;
			else gain_v = $urandom_range(0, 15);
			r = $urandom_range(99);
			if (r < 15) bias_v = $urandom_range(0, 1) ? 255 : -256;
			else bias_v = int'($urandom_range(0, 511)) - 256;
			apply_setup(w, h, split, gain_v, bias_v);
			repeat ($urandom_range(1, 3))
				run_frame(pix_style_t'($urandom_range(0, 2)), 0);
			phase++;
		end

		// Drain: stop the sender, let the last words out, bounded.
		in_valid  <= 1'b0;
		stall_pct <= 0;
		r = 0;
		while (sb.pending() != 0 && r < DRAIN_LIMIT) begin
			@(posedge clk);
			r++;
		end
		repeat (20) @(posedge clk);
		leftover = sb.pending();

		$display("covered %0d frames over %0d setups, %0d result words checked, %0d sharpened",
			sb.frames_done, phase + 4, sb.checked, sb.sharpened);
		$display("channel clamps low %0d high %0d, %0d early drain words ignored",
			sb.clamped_lo, sb.clamped_hi, sb.ignored_drains);
		if (sb.mismatches != 0) $display("%0d mismatching result words", sb.mismatches);
		if (leftover != 0) $display("%0d expected result words never arrived", leftover);
		if (sb.mismatches == 0 && leftover == 0) begin
			$display("tb_rgb_sharpen_3x3_clamp_top OK");
		end else begin
			$display("tb_rgb_sharpen_3x3_clamp_top NOT OK");
		end
		$finish;
	end

endmodule
